>>> hdl/bdlb_pkg.sv
// ----------------------------------------------------------------------------
// bdlb_pkg
// Shared types and constants for the button debounce / LED blinker core.
// ----------------------------------------------------------------------------
package bdlb_pkg;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [IDX_W-1:0] REG_LED1_PERIOD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LED2_PERIOD    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LED3_PERIOD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALT_PERIOD     = 3'd4;

  localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS = 16'd40;
  localparam logic [CNT_W-1:0] RST_LED1_PERIOD    = 16'd100;
  localparam logic [CNT_W-1:0] RST_LED2_PERIOD    = 16'd500;
  localparam logic [CNT_W-1:0] RST_LED3_PERIOD    = 16'd1000;
  localparam logic [CNT_W-1:0] RST_ALT_PERIOD     = 16'd500;

  typedef enum logic [1:0] {
    PH_UP,
    PH_FALLING,
    PH_DOWN,
    PH_RISING
  } phase_t;

  typedef struct packed {
    logic step;
    logic check;
    logic restart;
  } timer_ctrl_t;

endpackage

>>> hdl/bdlb_timer.sv
// ----------------------------------------------------------------------------
// bdlb_timer
// One-shot tick timer: a check while idle starts it, a check at or past the
// period reports expiry once and stops it. Restart clears and starts again.
// ----------------------------------------------------------------------------
module bdlb_timer
  import bdlb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  timer_ctrl_t      ctrl,
  input  logic [CNT_W-1:0] period,
  output logic             expire
);

  logic             running;
  logic             running_next;
  logic [CNT_W-1:0] elapsed;
  logic [CNT_W-1:0] elapsed_next;
  logic [CNT_W-1:0] elapsed_step;
  logic             reached;

  assign elapsed_step = (running && elapsed != CNT_MAX) ? elapsed + 1'b1 : elapsed;
  assign reached      = elapsed_step >= period;
  assign expire       = ctrl.step && ctrl.check && !ctrl.restart && running && reached;

  always_comb begin
    running_next = running;
    elapsed_next = elapsed_step;
    if (ctrl.restart) begin
      running_next = 1'b1;
      elapsed_next = '0;
    end else if (ctrl.check) begin
      if (!running) begin
        running_next = 1'b1;
        elapsed_next = '0;
      end else if (reached) begin
        running_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      elapsed <= '0;
    end else if (ctrl.step) begin
      running <= running_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

>>> hdl/bdlb_debounce.sv
// ----------------------------------------------------------------------------
// bdlb_debounce
// Four-phase debouncer (up, falling, down, rising) with its delay timer.
// Raises press for the tick on which a press is confirmed.
// ----------------------------------------------------------------------------
module bdlb_debounce
  import bdlb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             level,
  input  logic [CNT_W-1:0] debounce_ticks,
  output logic             press
);

  phase_t      phase;
  phase_t      phase_next;
  timer_ctrl_t tctrl;
  logic        check;
  logic        expire;

  assign tctrl = '{step: step, check: check, restart: 1'b0};

  bdlb_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (tctrl),
    .period (debounce_ticks),
    .expire (expire)
  );

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_UP:      if (level) phase_next = PH_FALLING;
      PH_FALLING: if (expire) phase_next = level ? PH_DOWN : PH_UP;
      PH_DOWN:    if (!level) phase_next = PH_RISING;
      PH_RISING:  if (expire) phase_next = level ? PH_DOWN : PH_UP;
      default:    phase_next = PH_UP;
    endcase
  end

  always_comb begin
    check = 1'b0;
    press = 1'b0;
    case (phase)
      PH_UP:      check = level;
      PH_FALLING: begin
        check = 1'b1;
        press = expire && level;
      end
      PH_DOWN:    check = !level;
      PH_RISING:  check = 1'b1;
      default:    check = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_UP;
    end else if (step) begin
      phase <= phase_next;
    end
  end

endmodule

>>> hdl/button_debounce_led_blinker_core.sv
// ----------------------------------------------------------------------------
// button_debounce_led_blinker_core
// Button debouncer driving a mode flag and three blinking LEDs.
// ----------------------------------------------------------------------------
// Each word on the s_ channel is one millisecond tick carrying the raw button
// level. For every accepted word one result word leaves on the m_ channel with
// the three LED levels, the mode flag and a press pulse.
// The tick's state update and its result are computed in the accepting cycle
// and held in the output register. Throughput is one word per cycle;
// s_tready stays high while the output register is empty or being taken, so
// a stalled receiver stalls the input after one word.
// Registers are written on the cfg_ channel (always ready); index 0 is the
// debounce delay, 1 to 3 the normal LED periods, 4 the alternate period;
// other indexes are ignored. Write only while the core is idle.
// Reset (rst, synchronous) restores the default periods, the up phase, LEDs
// off, normal mode and an empty output register.
// ----------------------------------------------------------------------------
module button_debounce_led_blinker_core
  import bdlb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [0] button_level
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [0] led1_on [1] led2_on [2] led3_on
                                      // [3] alternate_mode [4] press_event
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] debounce_ticks;
  logic [CNT_W-1:0] led_normal_period [3];
  logic [CNT_W-1:0] alternate_period;

  logic       accept;
  logic       press;
  logic       mode;
  logic       mode_next;
  logic [2:0] led_level;
  logic [2:0] led_level_next;
  logic [2:0] led_expire;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks       <= RST_DEBOUNCE_TICKS;
      led_normal_period[0] <= RST_LED1_PERIOD;
      led_normal_period[1] <= RST_LED2_PERIOD;
      led_normal_period[2] <= RST_LED3_PERIOD;
      alternate_period     <= RST_ALT_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks       <= cfg_data;
        REG_LED1_PERIOD:    led_normal_period[0] <= cfg_data;
        REG_LED2_PERIOD:    led_normal_period[1] <= cfg_data;
        REG_LED3_PERIOD:    led_normal_period[2] <= cfg_data;
        REG_ALT_PERIOD:     alternate_period     <= cfg_data;
        default: ;
      endcase
    end
  end

  bdlb_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .level          (s_tdata[0]),
    .debounce_ticks (debounce_ticks),
    .press          (press)
  );

  assign mode_next = mode ^ press;

  for (genvar i = 0; i < 3; i++) begin : g_led
    timer_ctrl_t      lctrl;
    logic [CNT_W-1:0] period;

    assign lctrl  = '{step: accept, check: 1'b1, restart: press};
    assign period = mode ? alternate_period : led_normal_period[i];

    bdlb_timer u_timer (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lctrl),
      .period (period),
      .expire (led_expire[i])
    );

    // entering alternate mode blanks the LEDs
    assign led_level_next[i] = (press && !mode) ? 1'b0 : led_level[i] ^ led_expire[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      led_level <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      led_level <= led_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, press, mode_next, led_level_next};
    end
  end

  a_accept_fills_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result word");

  a_mode_matches_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3] == mode)
    else $error("result mode differs from internal mode");

  a_alt_entry_blanks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4] && m_tdata[3]) |-> m_tdata[2:0] == 3'b000)
    else $error("LEDs not off on entering alternate mode");

  a_timer_quiet_on_press: assert property (@(posedge clk) disable iff (rst)
    (accept && press) |-> led_expire == 3'b000)
    else $error("LED timer expired on a press tick");

endmodule
